### hw/rtl/assert_macros.svh
// Assertion macros for the box filter downscaler RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define BFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed by a property on the next edge.
`define BFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bfd_pkg.sv
// Types, constants and lookup functions of the box filter downscaler.
// No dependencies; every RTL module and interface imports it.
package bfd_pkg;

  localparam int unsigned MaxFactor  = 16;
  localparam int unsigned RowLimit   = 1024;

  localparam int unsigned PixW       = 8;
  localparam int unsigned FacW       = 5;
  localparam int unsigned OffW       = 4;
  localparam int unsigned DimW       = 11;
  localparam int unsigned XW         = 11;
  localparam int unsigned YW         = 10;
  localparam int unsigned CoordW     = 10;
  localparam int unsigned SumW       = 16;
  localparam int unsigned NnW        = 9;
  localparam int unsigned HalfW      = 8;
  localparam int unsigned AvgInW     = 17;
  localparam int unsigned RecipW     = 26;
  localparam int unsigned RecipShift = 25;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 11;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_FACTOR     = 3'd0,
    CFG_COL_OFFSET = 3'd1,
    CFG_ROW_OFFSET = 3'd2,
    CFG_SRC_WIDTH  = 3'd3,
    CFG_SRC_ROWS   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0]   pixel;
    logic              zero;
    logic              emit;
    logic [CoordW-1:0] out_col;
    logic [CoordW-1:0] out_row;
    logic              last;
  } pix_ctl_t;

  typedef struct packed {
    logic [AvgInW-1:0] x;
    logic [CoordW-1:0] out_col;
    logic [CoordW-1:0] out_row;
    logic              last;
  } avg_in_t;

  function automatic logic [FacW-1:0] eff_factor(logic [FacW-1:0] f);
    logic [FacW-1:0] n;
    n = f;
    if (f == '0) begin
      n = FacW'(1);
    end else if (f > FacW'(MaxFactor)) begin
      n = FacW'(MaxFactor);
    end
    return n;
  endfunction

  function automatic logic [OffW-1:0] eff_offset(logic [OffW-1:0] off, logic [FacW-1:0] n);
    logic [FacW-1:0] nm1;
    nm1 = n - FacW'(1);
    return ({1'b0, off} >= n) ? nm1[OffW-1:0] : off;
  endfunction

  function automatic logic [DimW-1:0] eff_rows(logic [DimW-1:0] r);
    logic [DimW-1:0] v;
    v = r;
    if (r == '0) begin
      v = DimW'(1);
    end else if (r > DimW'(RowLimit)) begin
      v = DimW'(RowLimit);
    end
    return v;
  endfunction

  // ceil(2^25 / n^2): exact quotient for dividends below 2^17
  function automatic logic [RecipW-1:0] recip_f(logic [FacW-1:0] n);
    logic [RecipW-1:0] r;
    unique case (n)
      5'd1:    r = 26'd33554432;
      5'd2:    r = 26'd8388608;
      5'd3:    r = 26'd3728271;
      5'd4:    r = 26'd2097152;
      5'd5:    r = 26'd1342178;
      5'd6:    r = 26'd932068;
      5'd7:    r = 26'd684785;
      5'd8:    r = 26'd524288;
      5'd9:    r = 26'd414253;
      5'd10:   r = 26'd335545;
      5'd11:   r = 26'd277310;
      5'd12:   r = 26'd233017;
      5'd13:   r = 26'd198547;
      5'd14:   r = 26'd171197;
      5'd15:   r = 26'd149131;
      default: r = 26'd131072;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/bfd_pix_if.sv
// Source pixel channel of the box filter downscaler.
// Depends on bfd_pkg for the pixel width.
interface bfd_pix_if import bfd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

### hw/rtl/bfd_res_if.sv
// Result channel of the box filter downscaler: one averaged output pixel per item.
// Depends on bfd_pkg for field widths.
interface bfd_res_if import bfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PixW-1:0]   avg_alpha;
  logic [CoordW-1:0] out_col;
  logic [CoordW-1:0] out_row;
  logic              last;

  modport source (output valid, output avg_alpha, output out_col, output out_row,
                  output last, input ready);
  modport sink   (input valid, input avg_alpha, input out_col, input out_row,
                  input last, output ready);
endinterface

### hw/rtl/bfd_cfg_if.sv
// Configuration write channel of the box filter downscaler.
// Depends on bfd_pkg for the index and data widths.
interface bfd_cfg_if import bfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/bfd_ctrl.sv
// Configuration registers and raster position counters of the downscaler.
// Depends on bfd_pkg and assert_macros.svh; issues the column sum read address.
`include "assert_macros.svh"

module bfd_ctrl import bfd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [CfgAddrW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]          cfg_data_i,
  input  logic                         acc_i,
  input  logic [PixW-1:0]              pixel_i,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr_o,
  output pix_ctl_t                     ctl_o,
  output logic [FacW-1:0]              n_o
);

  localparam int unsigned AddrW    = $clog2(MAX_WIDTH);
  localparam int unsigned IdxW     = (AddrW > XW) ? AddrW : XW;
  localparam int unsigned WidthCap = (MAX_WIDTH < ((1 << DimW) - 1)) ?
                                     MAX_WIDTH : ((1 << DimW) - 1);

  logic [FacW-1:0] factor_q, factor_d;
  logic [OffW-1:0] col_offset_q, col_offset_d;
  logic [OffW-1:0] row_offset_q, row_offset_d;
  logic [DimW-1:0] src_width_q, src_width_d;
  logic [DimW-1:0] src_rows_q, src_rows_d;
  logic            restart;

  logic [XW-1:0]   src_x_q, src_x_d;
  logic [YW-1:0]   src_y_q, src_y_d;
  logic [XW-1:0]   out_x_q, out_x_d;
  logic [YW-1:0]   out_y_q, out_y_d;
  logic [OffW-1:0] phase_x_q, phase_x_d;
  logic [OffW-1:0] phase_y_q, phase_y_d;

  logic [FacW-1:0] n_q, n_d, nm1_full;
  logic [OffW-1:0] nm1;
  logic [DimW-1:0] w, wm1, rows, rm1;
  logic [OffW-1:0] px_ld, py_ld;
  logic            row_end, last_row, img_end, close_col, close_row;
  logic [IdxW-1:0] idx_ext, idx_cap;

  always_comb begin
    factor_d     = factor_q;
    col_offset_d = col_offset_q;
    row_offset_d = row_offset_q;
    src_width_d  = src_width_q;
    src_rows_d   = src_rows_q;
    restart      = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FACTOR: begin
          factor_d = cfg_data_i[FacW-1:0];
          restart  = 1'b1;
        end
        CFG_COL_OFFSET: begin
          col_offset_d = cfg_data_i[OffW-1:0];
          restart      = 1'b1;
        end
        CFG_ROW_OFFSET: begin
          row_offset_d = cfg_data_i[OffW-1:0];
          restart      = 1'b1;
        end
        CFG_SRC_WIDTH: begin
          src_width_d = cfg_data_i[DimW-1:0];
          restart     = 1'b1;
        end
        CFG_SRC_ROWS: begin
          src_rows_d = cfg_data_i[DimW-1:0];
          restart    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q     <= FacW'(16);
      col_offset_q <= '0;
      row_offset_q <= '0;
      src_width_q  <= DimW'(1024);
      src_rows_q   <= DimW'(1024);
    end else begin
      factor_q     <= factor_d;
      col_offset_q <= col_offset_d;
      row_offset_q <= row_offset_d;
      src_width_q  <= src_width_d;
      src_rows_q   <= src_rows_d;
    end
  end

  always_comb begin
    n_q      = eff_factor(factor_q);
    n_d      = eff_factor(factor_d);
    nm1_full = n_q - FacW'(1);
    nm1      = nm1_full[OffW-1:0];
    px_ld    = eff_offset(col_offset_d, n_d);
    py_ld    = eff_offset(row_offset_d, n_d);

    if (src_width_q == '0) begin
      w = DimW'(1);
    end else if (src_width_q > DimW'(WidthCap)) begin
      w = DimW'(WidthCap);
    end else begin
      w = src_width_q;
    end
    wm1  = w - DimW'(1);
    rows = eff_rows(src_rows_q);
    rm1  = rows - DimW'(1);

    row_end   = src_x_q >= wm1;
    last_row  = DimW'(src_y_q) >= rm1;
    img_end   = row_end && last_row;
    close_col = (phase_x_q >= nm1) || row_end;
    close_row = (phase_y_q >= nm1) || last_row;

    idx_ext   = IdxW'(out_x_q);
    idx_cap   = IdxW'(MAX_WIDTH - 1);
    if (idx_ext > idx_cap) begin
      idx_ext = idx_cap;
    end
  end

  assign rd_addr_o     = idx_ext[AddrW-1:0];
  assign n_o           = n_q;
  assign ctl_o.pixel   = pixel_i;
  assign ctl_o.zero    = (src_y_q == '0) && ((src_x_q == '0) || (phase_x_q == '0));
  assign ctl_o.emit    = close_col && close_row;
  assign ctl_o.out_col = out_x_q[CoordW-1:0];
  assign ctl_o.out_row = out_y_q[CoordW-1:0];
  assign ctl_o.last    = img_end;

  always_comb begin
    src_x_d   = src_x_q;
    src_y_d   = src_y_q;
    out_x_d   = out_x_q;
    out_y_d   = out_y_q;
    phase_x_d = phase_x_q;
    phase_y_d = phase_y_q;
    if (restart || (acc_i && img_end)) begin
      src_x_d   = '0;
      src_y_d   = '0;
      out_x_d   = '0;
      out_y_d   = '0;
      phase_x_d = px_ld;
      phase_y_d = py_ld;
    end else if (acc_i && row_end) begin
      src_x_d   = '0;
      out_x_d   = '0;
      phase_x_d = px_ld;
      src_y_d   = src_y_q + YW'(1);
      if (phase_y_q >= nm1) begin
        phase_y_d = '0;
        out_y_d   = out_y_q + YW'(1);
      end else begin
        phase_y_d = phase_y_q + OffW'(1);
      end
    end else if (acc_i) begin
      src_x_d = src_x_q + XW'(1);
      if (phase_x_q >= nm1) begin
        phase_x_d = '0;
        out_x_d   = out_x_q + XW'(1);
      end else begin
        phase_x_d = phase_x_q + OffW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_x_q   <= '0;
      src_y_q   <= '0;
      out_x_q   <= '0;
      out_y_q   <= '0;
      phase_x_q <= '0;
      phase_y_q <= '0;
    end else begin
      src_x_q   <= src_x_d;
      src_y_q   <= src_y_d;
      out_x_q   <= out_x_d;
      out_y_q   <= out_y_d;
      phase_x_q <= phase_x_d;
      phase_y_q <= phase_y_d;
    end
  end

  `BFD_ASSERT(a_phase_x_range, phase_x_q <= nm1, "column phase beyond cell size")
  `BFD_ASSERT(a_phase_y_range, phase_y_q <= nm1, "row phase beyond cell size")
  `BFD_ASSERT(a_src_x_range, src_x_q <= XW'(wm1), "source column beyond row width")
  `BFD_ASSERT_NEXT(a_restart_clears, restart, (src_x_q == '0) && (src_y_q == '0) && (out_x_q == '0) && (out_y_q == '0), "counters not cleared after register write")

endmodule

### hw/rtl/bfd_acc.sv
// Column sum memory with read-modify-write, write forwarding and band close.
// Depends on bfd_pkg; feeds the rounded-divide stage.
module bfd_acc import bfd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         acc_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  pix_ctl_t                     ctl_i,
  input  logic [FacW-1:0]              n_i,
  output logic                         c_valid_o,
  output avg_in_t                      c_o
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);

  logic [SumW-1:0]  sum_mem [MAX_WIDTH];
  logic [SumW-1:0]  rd_data_q;

  logic             b_valid_q;
  pix_ctl_t         b_ctl_q;
  logic [AddrW-1:0] b_idx_q;

  logic             fw_valid_q;
  logic [AddrW-1:0] fw_addr_q;
  logic [SumW-1:0]  fw_data_q;

  logic             c_valid_q;
  avg_in_t          c_q, c_d;

  logic [SumW-1:0]  base, sum, wr_data;
  logic             wr_en;
  logic [NnW-1:0]   nn;
  logic [HalfW-1:0] half;

  always_comb begin
    if (b_ctl_q.zero) begin
      base = '0;
    end else if (fw_valid_q && (fw_addr_q == b_idx_q)) begin
      base = fw_data_q;
    end else begin
      base = rd_data_q;
    end
    sum     = base + SumW'(b_ctl_q.pixel);
    wr_data = b_ctl_q.emit ? '0 : sum;
    wr_en   = adv_i && b_valid_q;
    nn      = NnW'(n_i) * NnW'(n_i);
    half    = nn[NnW-1:1];
    c_d.x       = AvgInW'(sum) + AvgInW'(half);
    c_d.out_col = b_ctl_q.out_col;
    c_d.out_row = b_ctl_q.out_row;
    c_d.last    = b_ctl_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_data_q <= sum_mem[rd_addr_i];
    end
    if (wr_en) begin
      sum_mem[b_idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      fw_valid_q <= 1'b0;
      c_valid_q  <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= acc_i;
      c_valid_q <= b_valid_q && b_ctl_q.emit;
      if (b_valid_q) begin
        fw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      b_ctl_q <= ctl_i;
      b_idx_q <= rd_addr_i;
    end
    if (wr_en) begin
      fw_addr_q <= b_idx_q;
      fw_data_q <= wr_data;
      c_q       <= c_d;
    end
  end

  assign c_valid_o = c_valid_q;
  assign c_o       = c_q;

endmodule

### hw/rtl/bfd_avg.sv
// Rounded divide by the cell area through a reciprocal multiply, and output register.
// Depends on bfd_pkg for the reciprocal table.
module bfd_avg import bfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              c_valid_i,
  input  avg_in_t           c_i,
  input  logic [FacW-1:0]   n_i,
  output logic              res_valid_o,
  output logic [PixW-1:0]   res_avg_o,
  output logic [CoordW-1:0] res_col_o,
  output logic [CoordW-1:0] res_row_o,
  output logic              res_last_o
);

  localparam int unsigned ProdW = AvgInW + RecipW;

  logic [ProdW-1:0]  prod;
  logic              res_valid_q;
  logic [PixW-1:0]   avg_q;
  logic [CoordW-1:0] col_q, row_q;
  logic              last_q;

  assign prod = ProdW'(c_i.x) * ProdW'(recip_f(n_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      res_valid_q <= c_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && c_valid_i) begin
      avg_q  <= prod[RecipShift+PixW-1:RecipShift];
      col_q  <= c_i.out_col;
      row_q  <= c_i.out_row;
      last_q <= c_i.last;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_avg_o   = avg_q;
  assign res_col_o   = col_q;
  assign res_row_o   = row_q;
  assign res_last_o  = last_q;

endmodule

### hw/rtl/box_filter_downscale.sv
// Streaming n-by-n box filter downscaler for an 8-bit alpha bitmap. Feed the visible
// pixels in row-major order; one pixel is taken every clock while the result register
// is free or being emptied, and the pixel that closes a cell passes the read, sum and
// output registers. Throughput is set by the single read and single write port of the
// column sum memory (MAX_WIDTH entries of 16 bits): each pixel does one read, one add
// and one write back, with the previous write forwarded when the same column follows.
// The memory needs no clearing pass: sums are taken as zero on the first source row
// after reset, a register write or the end of an image. A write to one of the five
// registers restarts the image; write registers only while the block is idle.
module box_filter_downscale import bfd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bfd_pix_if.sink  pix_i,
  bfd_res_if.source res_o,
  bfd_cfg_if.sink  cfg_i
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);

  logic             adv, acc;
  logic [AddrW-1:0] rd_addr;
  pix_ctl_t         ctl;
  logic [FacW-1:0]  n;
  logic             c_valid;
  avg_in_t          c_data;

  assign adv         = !res_o.valid || res_o.ready;
  assign acc         = pix_i.valid && adv;
  assign pix_i.ready = adv;
  assign cfg_i.ready = 1'b1;

  bfd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .acc_i       (acc),
    .pixel_i     (pix_i.pixel),
    .rd_addr_o   (rd_addr),
    .ctl_o       (ctl),
    .n_o         (n)
  );

  bfd_acc #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .acc_i     (acc),
    .rd_addr_i (rd_addr),
    .ctl_i     (ctl),
    .n_i       (n),
    .c_valid_o (c_valid),
    .c_o       (c_data)
  );

  bfd_avg u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .c_valid_i   (c_valid),
    .c_i         (c_data),
    .n_i         (n),
    .res_valid_o (res_o.valid),
    .res_avg_o   (res_o.avg_alpha),
    .res_col_o   (res_o.out_col),
    .res_row_o   (res_o.out_row),
    .res_last_o  (res_o.last)
  );

endmodule

### test/bfd_cell_average_monitor.sv
`timescale 1ns / 100ps
// Watches the pixel, result and configuration channels of box_filter_downscale,
// predicts every averaged cell from the accepted pixels and compares the results.
// Depends on bfd_pkg and the three channel interfaces.
module bfd_cell_average_monitor import bfd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  bfd_pix_if   pix_i,
  bfd_res_if   res_i,
  bfd_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   predicted_o
);

  typedef struct packed {
    logic [PixW-1:0]   avg_alpha;
    logic [CoordW-1:0] out_col;
    logic [CoordW-1:0] out_row;
    logic              last;
  } cell_avg_t;

  logic [FacW-1:0] factor_q;
  logic [OffW-1:0] col_off_q;
  logic [OffW-1:0] row_off_q;
  logic [DimW-1:0] width_q;
  logic [DimW-1:0] rows_q;

  logic [SumW-1:0] col_sum [MAX_WIDTH];
  int unsigned     src_col, src_row, cell_col, cell_row, ph_x, ph_y;

  cell_avg_t cell_q [$];
  int        fails = 0;
  int        predicted = 0;

  assign fail_count_o = fails;
  assign predicted_o  = predicted;

  function automatic int unsigned side();
    if (factor_q == '0) return 1;
    if (factor_q > MaxFactor) return MaxFactor;
    return factor_q;
  endfunction

  function automatic int unsigned start_phase(logic [OffW-1:0] off);
    int unsigned n;
    n = side();
    return (off >= n) ? n - 1 : off;
  endfunction

  function automatic int unsigned span(logic [DimW-1:0] v, int unsigned cap);
    if (v == '0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic void rewind();
    src_col  = 0;
    src_row  = 0;
    cell_col = 0;
    cell_row = 0;
    ph_x     = start_phase(col_off_q);
    ph_y     = start_phase(row_off_q);
  endfunction

  function automatic void restart_image();
    foreach (col_sum[i]) col_sum[i] = '0;
    rewind();
  endfunction

  function automatic void apply_write(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] d);
    case (idx)
      CFG_FACTOR:     factor_q  = d[FacW-1:0];
      CFG_COL_OFFSET: col_off_q = d[OffW-1:0];
      CFG_ROW_OFFSET: row_off_q = d[OffW-1:0];
      CFG_SRC_WIDTH:  width_q   = d[DimW-1:0];
      CFG_SRC_ROWS:   rows_q    = d[DimW-1:0];
      default:        return;
    endcase
    restart_image();
  endfunction

  function automatic void accumulate(logic [PixW-1:0] pix);
    int unsigned n, w, h, nn;
    logic        row_end, img_end, shut_x, shut_y;
    cell_avg_t   c;
    n       = side();
    w       = span(width_q, MAX_WIDTH);
    h       = span(rows_q, RowLimit);
    row_end = src_col >= w - 1;
    img_end = row_end && src_row >= h - 1;
    shut_x  = ph_x >= n - 1 || row_end;
    shut_y  = ph_y >= n - 1 || src_row >= h - 1;
    col_sum[cell_col] = col_sum[cell_col] + SumW'(pix);
    if (shut_x && shut_y) begin
      nn          = n * n;
      c.avg_alpha = PixW'((col_sum[cell_col] + nn / 2) / nn);
      c.out_col   = CoordW'(cell_col);
      c.out_row   = CoordW'(cell_row);
      c.last      = img_end;
      cell_q      = {cell_q, c};
      predicted++;
      col_sum[cell_col] = '0;
    end
    if (img_end) begin
      rewind();
    end else if (row_end) begin
      src_col  = 0;
      cell_col = 0;
      ph_x     = start_phase(col_off_q);
      src_row++;
      if (ph_y >= n - 1) begin
        ph_y = 0;
        cell_row++;
      end else begin
        ph_y++;
      end
    end else begin
      src_col++;
      if (ph_x >= n - 1) begin
        ph_x = 0;
        cell_col++;
      end else begin
        ph_x++;
      end
    end
  endfunction

  function automatic bit field_differs(string name, logic [CoordW-1:0] want,
                                       logic [CoordW-1:0] got);
    if (want === got) return 1'b0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_avg_t want;
    bit        bad;
    if (!rst_ni) begin
      factor_q  = FacW'(MaxFactor);
      col_off_q = '0;
      row_off_q = '0;
      width_q   = DimW'(MAX_WIDTH);
      rows_q    = DimW'(RowLimit);
      restart_image();
      cell_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) apply_write(cfg_i.index, cfg_i.data);
      if (pix_i.valid && pix_i.ready) accumulate(pix_i.pixel);
      if (res_i.valid && res_i.ready) begin
        if (cell_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0b",
                   $time, res_i.avg_alpha, res_i.out_col, res_i.out_row, res_i.last);
        end else begin
          want = cell_q.pop_front();
          bad  = field_differs("avg_alpha", CoordW'(want.avg_alpha),
                               CoordW'(res_i.avg_alpha));
          bad |= field_differs("out_col", want.out_col, res_i.out_col);
          bad |= field_differs("out_row", want.out_row, res_i.out_row);
          bad |= field_differs("last", CoordW'(want.last), CoordW'(res_i.last));
          if (bad) fails++;
        end
      end
    end
    pending_o = cell_q.size();
  end

endmodule

### test/tb_box_filter_downscale.sv
`timescale 1ns / 100ps
// Top of the box_filter_downscale testbench: clock, reset, settings, pixel stream and
// result back-pressure; the verdict comes from bfd_cell_average_monitor.
// Depends on bfd_pkg, the channel interfaces, the block and the monitor.
module tb_box_filter_downscale;
  import bfd_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int LimitCycles  = 2_000_000;
  localparam int RandomItems  = 1550;
  localparam int MinResults   = 60;
  localparam int DrainCycles  = 16;
  localparam int HoldCycles   = 400;
  localparam int WideRow      = 1024;
  localparam logic [CfgAddrW-1:0] CfgSpareLo = 3'd5;
  localparam logic [CfgAddrW-1:0] CfgSpareHi = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet = 1'b0;
  bit   squeeze_req = 1'b0;
  int   fed = 0;
  int   fails, pending, predicted;

  bfd_pix_if pix_if ();
  bfd_res_if res_if ();
  bfd_cfg_if cfg_if ();

  box_filter_downscale i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  bfd_cell_average_monitor i_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pix_i        (pix_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fails),
    .pending_o    (pending),
    .predicted_o  (predicted)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("[box_filter_downscale] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [PixW-1:0] random_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PixW'($urandom_range(0, 255));
  endfunction

  // fill the unused upper data bits with noise
  function automatic logic [CfgDataW-1:0] with_noise(int v, int w);
    logic [CfgDataW-1:0] d;
    d = CfgDataW'($urandom);
    return ((d >> w) << w) | CfgDataW'(v);
  endfunction

  task automatic cfg_write(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic load_settings(int fac, int coff, int roff, int wid, int rws, bit spare);
    cfg_write(CFG_FACTOR, with_noise(fac, FacW));
    cfg_write(CFG_COL_OFFSET, with_noise(coff, OffW));
    cfg_write(CFG_ROW_OFFSET, with_noise(roff, OffW));
    cfg_write(CFG_SRC_WIDTH, CfgDataW'(wid));
    cfg_write(CFG_SRC_ROWS, CfgDataW'(rws));
    if (spare) cfg_write(CfgAddrW'($urandom_range(CfgSpareLo, CfgSpareHi)), CfgDataW'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [PixW-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= p;
    do @(posedge clk); while (!pix_if.ready);
    @(negedge clk);
    fed++;
  endtask

  // drop valid, then wait until every cell has arrived and the pipeline is empty
  task automatic finish_phase();
    pix_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic random_phase();
    int r, fac, wid, rws, n_items;
    r   = $urandom_range(0, 9);
    fac = (r < 8) ? $urandom_range(1, 4) : (r == 8) ? $urandom_range(5, 16)
                                                    : $urandom_range(0, 31);
    wid = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(0, 2047);
    rws = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(0, 2047);
    quiet = ($urandom_range(0, 7) == 0);
    load_settings(fac, $urandom_range(0, 15), $urandom_range(0, 15), wid, rws,
                  $urandom_range(0, 3) == 0);
    n_items = (wid == 0 ? 1 : wid) * (rws == 0 ? 1 : rws) * $urandom_range(1, 3);
    if (n_items > 150) n_items = $urandom_range(20, 150);
    repeat (n_items) send_pixel(random_pixel());
    finish_phase();
  endtask

  initial begin
    int gap;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        squeeze_req = 1'b0;
        res_if.ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          res_if.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_FACTOR;
    cfg_if.data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-pixel images: zero factor, width and rows, offsets clamped
    load_settings(0, 5, 15, 0, 0, 1'b0);
    send_pixel('1);
    send_pixel('0);
    send_pixel('1);
    finish_phase();

    // two small images with zero-padded edge cells
    load_settings(2, 1, 1, 3, 2, 1'b0);
    for (int i = 0; i < 12; i++) begin
      send_pixel((i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'h5A);
    end
    finish_phase();

    // factor, width and rows above range, offsets at the top, spare register write
    load_settings(31, 15, 15, 2047, 2047, 1'b1);
    send_pixel('1);
    send_pixel('1);
    send_pixel('0);
    send_pixel(8'h80);
    send_pixel('1);
    finish_phase();

    fed = 0;
    load_settings($urandom_range(1, 16), $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(WideRow, 2047), 1, 1'b0);
    repeat (WideRow) send_pixel(random_pixel());
    finish_phase();

    // hold off the result side while pixels keep coming
    quiet = 1'b1;
    load_settings(1, 0, 0, 32, 8, 1'b0);
    squeeze_req = 1'b1;
    repeat (256) send_pixel(random_pixel());
    finish_phase();
    quiet = 1'b0;

    while (fed < RandomItems || predicted < MinResults) random_phase();

    quiet = 1'b0;
    finish_phase();
    if (fails == 0) begin
      $display("[box_filter_downscale] OK");
    end else begin
      $display("[box_filter_downscale] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_pix_if.sv
hw/rtl/bfd_res_if.sv
hw/rtl/bfd_cfg_if.sv
hw/rtl/bfd_ctrl.sv
hw/rtl/bfd_acc.sv
hw/rtl/bfd_avg.sv
hw/rtl/box_filter_downscale.sv
test/bfd_cell_average_monitor.sv
test/tb_box_filter_downscale.sv
